/* hw/rtl/cpo_pkg.sv */
package cpo_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int RAD_WIDTH   = COORD_WIDTH - 1;
  localparam int DELTA_WIDTH = COORD_WIDTH + 1;
  localparam int MAG_WIDTH   = COORD_WIDTH;
  localparam int SUM_WIDTH   = COORD_WIDTH;
  localparam int SQ_WIDTH    = 2 * MAG_WIDTH + 1;
  localparam int ROOT_WIDTH  = (SQ_WIDTH + 1) / 2;
  localparam int NORM_FRAC   = 14;
  localparam int NUM_WIDTH   = MAG_WIDTH + NORM_FRAC;
  localparam int QUO_WIDTH   = NORM_FRAC + 2;
  localparam int OUT_WIDTH   = 16;
  localparam logic [SQ_WIDTH-1:0] EPS_Q = SQ_WIDTH'((64'd1 << (2 * FRAC_BITS)) / 64'd10000);

  // one root pair of bits per stage
  localparam int ROOT_STEPS = ROOT_WIDTH;
  // one quotient bit per stage
  localparam int DIV_STEPS  = QUO_WIDTH;

  // item carried through the root pipeline
  typedef struct packed {
    logic                  hit;
    logic                  neg_x;
    logic                  neg_y;
    logic [MAG_WIDTH-1:0]  mag_x;
    logic [MAG_WIDTH-1:0]  mag_y;
    logic [SUM_WIDTH-1:0]  rsum;
  } cpo_ctl_t;

endpackage

/* hw/rtl/circle_pair_overlap_test_core.sv */
// channel | valid     | stall     | beat fields
// in      | in_valid  | in_stall  | a_x a_y a_radius b_x b_y b_radius
// out     | out_valid | out_stall | hit normal_x normal_y penetration
//
// one beat per cycle while the pipe is not frozen; register stages: 3 front + 17 root + 17
// divide and sign + 1 output queue, set by one root bit and one quotient bit per stage
// a two-entry skid buffer at the output keeps the pipe moving while a
// finished beat waits; the pipe only freezes when the skid is full
// rst clears all valid bits, including those of the skid buffer
module circle_pair_overlap_test_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [cpo_pkg::COORD_WIDTH-1:0] a_x,
  input  logic signed [cpo_pkg::COORD_WIDTH-1:0] a_y,
  input  logic        [cpo_pkg::RAD_WIDTH-1:0]   a_radius,
  input  logic signed [cpo_pkg::COORD_WIDTH-1:0] b_x,
  input  logic signed [cpo_pkg::COORD_WIDTH-1:0] b_y,
  input  logic        [cpo_pkg::RAD_WIDTH-1:0]   b_radius,
  output logic out_valid,
  input  logic out_stall,
  output logic hit,
  output logic signed [cpo_pkg::OUT_WIDTH-1:0] normal_x,
  output logic signed [cpo_pkg::OUT_WIDTH-1:0] normal_y,
  output logic [cpo_pkg::OUT_WIDTH-1:0] penetration
);
  import cpo_pkg::*;

  localparam int RW = 1 + 3 * OUT_WIDTH;

  logic en, fv, sv, pv;
  cpo_ctl_t fc, sc;
  logic [SQ_WIDTH-1:0]   d2;
  logic [ROOT_WIDTH-1:0] root;
  logic p_hit;
  logic signed [OUT_WIDTH-1:0] p_nx, p_ny;
  logic [OUT_WIDTH-1:0] p_pen;

  cpo_front u_front (.clk, .rst, .en, .in_valid(in_valid), .a_x, .a_y, .a_radius,
    .b_x, .b_y, .b_radius, .out_valid(fv), .ctl(fc), .d2);
  cpo_sqrt u_sqrt (.clk, .rst, .en, .in_valid(fv), .in_ctl(fc), .d2,
    .out_valid(sv), .out_ctl(sc), .root);
  cpo_norm u_norm (.clk, .rst, .en, .in_valid(sv), .in_ctl(sc), .root,
    .out_valid(pv), .hit(p_hit), .normal_x(p_nx), .normal_y(p_ny),
    .penetration(p_pen));

  // two-entry output queue
  logic [RW-1:0] q [2];
  logic          qv [2];
  logic          push, pop;

  // pipe advances while the queue has a free slot or the pipe's final output slot is empty
  assign en       = !qv[1] || !pv;
  assign in_stall = !en;
  assign push     = pv && en;
  assign pop      = qv[0] && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
      qv[1] <= 1'b0;
    end else begin
      if (pop) begin
        qv[0] <= qv[1] || push;
        qv[1] <= qv[1] && push;
      end else if (push) begin
        qv[0] <= 1'b1;
        qv[1] <= qv[0];
      end
    end
    if (pop) begin
      q[0] <= qv[1] ? q[1] : {p_hit, p_nx, p_ny, p_pen};
      q[1] <= {p_hit, p_nx, p_ny, p_pen};
    end else if (push) begin
      if (qv[0]) q[1] <= {p_hit, p_nx, p_ny, p_pen};
      else       q[0] <= {p_hit, p_nx, p_ny, p_pen};
    end
  end

  assign out_valid = qv[0];
  assign {hit, normal_x, normal_y, penetration} = q[0];

  a_order: assert property (@(posedge clk) disable iff (rst) qv[1] |-> qv[0])
    else $error("queue tail valid without head");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (normal_x == '0 && normal_y == '0 && penetration == '0))
    else $error("miss with nonzero fields");
  a_hit_pen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (penetration != '0))
    else $error("hit with zero penetration");

endmodule

/* hw/rtl/cpo_front.sv */
module cpo_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [cpo_pkg::COORD_WIDTH-1:0] a_x,
  input  logic signed [cpo_pkg::COORD_WIDTH-1:0] a_y,
  input  logic        [cpo_pkg::RAD_WIDTH-1:0]   a_radius,
  input  logic signed [cpo_pkg::COORD_WIDTH-1:0] b_x,
  input  logic signed [cpo_pkg::COORD_WIDTH-1:0] b_y,
  input  logic        [cpo_pkg::RAD_WIDTH-1:0]   b_radius,
  output logic                          out_valid,
  output cpo_pkg::cpo_ctl_t             ctl,
  output logic [cpo_pkg::SQ_WIDTH-1:0]  d2
);
  import cpo_pkg::*;

  logic                 v1, v2;
  logic                 nx1, ny1;
  logic [MAG_WIDTH-1:0] mx1, my1;
  logic [SUM_WIDTH-1:0] rs1;
  logic signed [DELTA_WIDTH-1:0] dx, dy;
  logic [SQ_WIDTH-1:0]  sqx2, sqy2, rs2_2;
  cpo_ctl_t             c2;

  assign dx = DELTA_WIDTH'(b_x) - DELTA_WIDTH'(a_x);
  assign dy = DELTA_WIDTH'(b_y) - DELTA_WIDTH'(a_y);

  // stage 1: delta, magnitudes, radius sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      nx1 <= dx[DELTA_WIDTH-1];
      ny1 <= dy[DELTA_WIDTH-1];
      mx1 <= MAG_WIDTH'(dx[DELTA_WIDTH-1] ? -dx : dx);
      my1 <= MAG_WIDTH'(dy[DELTA_WIDTH-1] ? -dy : dy);
      rs1 <= SUM_WIDTH'(a_radius) + SUM_WIDTH'(b_radius);
    end
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      sqx2  <= SQ_WIDTH'(mx1 * mx1);
      sqy2  <= SQ_WIDTH'(my1 * my1);
      rs2_2 <= SQ_WIDTH'(rs1 * rs1);
      c2.neg_x <= nx1;
      c2.neg_y <= ny1;
      c2.mag_x <= mx1;
      c2.mag_y <= my1;
      c2.rsum  <= rs1;
      c2.hit   <= 1'b0;
    end
  end

  logic [SQ_WIDTH-1:0] sum2;
  assign sum2 = sqx2 + sqy2;

  // stage 3: sum and hit compare
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      d2        <= sum2;
      ctl.neg_x <= c2.neg_x;
      ctl.neg_y <= c2.neg_y;
      ctl.mag_x <= c2.mag_x;
      ctl.mag_y <= c2.mag_y;
      ctl.rsum  <= c2.rsum;
      ctl.hit   <= (sum2 < rs2_2) && (sum2 > EPS_Q);
    end
  end

endmodule

/* hw/rtl/cpo_sqrt.sv */
module cpo_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  cpo_pkg::cpo_ctl_t               in_ctl,
  input  logic [cpo_pkg::SQ_WIDTH-1:0]    d2,
  output logic                            out_valid,
  output cpo_pkg::cpo_ctl_t               out_ctl,
  output logic [cpo_pkg::ROOT_WIDTH-1:0]  root
);
  import cpo_pkg::*;

  localparam int RW = ROOT_WIDTH + 2;
  localparam int PW = 2 * ROOT_WIDTH;

  logic                 v   [ROOT_STEPS+1];
  cpo_ctl_t             c   [ROOT_STEPS+1];
  logic [PW-1:0]        rad [ROOT_STEPS+1];
  logic [RW-1:0]        rem [ROOT_STEPS+1];
  logic [ROOT_WIDTH-1:0] rt [ROOT_STEPS+1];

  assign v[0]   = in_valid;
  assign c[0]   = in_ctl;
  assign rad[0] = PW'(d2);
  assign rem[0] = '0;
  assign rt[0]  = '0;

  // restoring root, one result bit per stage
  for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
    logic [RW-1:0] trial, rem_sh;
    assign rem_sh = {rem[s][RW-3:0], rad[s][PW-1 -: 2]};
    assign trial  = {rt[s], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        c[s+1]   <= c[s];
        rad[s+1] <= {rad[s][PW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem[s+1] <= rem_sh - trial;
          rt[s+1]  <= {rt[s][ROOT_WIDTH-2:0], 1'b1};
        end else begin
          rem[s+1] <= rem_sh;
          rt[s+1]  <= {rt[s][ROOT_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[ROOT_STEPS];
  assign out_ctl   = c[ROOT_STEPS];
  assign root      = rt[ROOT_STEPS];

endmodule

/* hw/rtl/cpo_norm.sv */
module cpo_norm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  cpo_pkg::cpo_ctl_t               in_ctl,
  input  logic [cpo_pkg::ROOT_WIDTH-1:0]  root,
  output logic                            out_valid,
  output logic                            hit,
  output logic signed [cpo_pkg::OUT_WIDTH-1:0] normal_x,
  output logic signed [cpo_pkg::OUT_WIDTH-1:0] normal_y,
  output logic [cpo_pkg::OUT_WIDTH-1:0]   penetration
);
  import cpo_pkg::*;

  localparam int DW = ROOT_WIDTH;
  localparam int RW = DW + 1;

  logic                 v   [DIV_STEPS+1];
  cpo_ctl_t             c   [DIV_STEPS+1];
  logic [DW-1:0]        dv  [DIV_STEPS+1];
  logic [NUM_WIDTH-1:0] nxs [DIV_STEPS+1];
  logic [NUM_WIDTH-1:0] nys [DIV_STEPS+1];
  logic [RW-1:0]        rx  [DIV_STEPS+1];
  logic [RW-1:0]        ry  [DIV_STEPS+1];
  logic [QUO_WIDTH-1:0] qx  [DIV_STEPS+1];
  logic [QUO_WIDTH-1:0] qy  [DIV_STEPS+1];

  assign v[0]  = in_valid;
  assign c[0]  = in_ctl;
  assign dv[0] = (root == '0) ? DW'(1) : root;
  // the top bits of the numerator give a quotient below 2^QUO_WIDTH, start there
  assign rx[0] = RW'(in_ctl.mag_x >> (QUO_WIDTH - NORM_FRAC));
  assign ry[0] = RW'(in_ctl.mag_y >> (QUO_WIDTH - NORM_FRAC));
  assign nxs[0] = NUM_WIDTH'(in_ctl.mag_x) << (NUM_WIDTH
                  - (QUO_WIDTH - NORM_FRAC));
  assign nys[0] = NUM_WIDTH'(in_ctl.mag_y) << (NUM_WIDTH
                  - (QUO_WIDTH - NORM_FRAC));
  assign qx[0] = '0;
  assign qy[0] = '0;

  // restoring division, one quotient bit per stage on both axes
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [RW-1:0] shx, shy;
    assign shx = {rx[s][RW-2:0], nxs[s][NUM_WIDTH-1]};
    assign shy = {ry[s][RW-2:0], nys[s][NUM_WIDTH-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        c[s+1]   <= c[s];
        dv[s+1]  <= dv[s];
        nxs[s+1] <= {nxs[s][NUM_WIDTH-2:0], 1'b0};
        nys[s+1] <= {nys[s][NUM_WIDTH-2:0], 1'b0};
        if (shx >= RW'(dv[s])) begin
          rx[s+1] <= shx - RW'(dv[s]);
          qx[s+1] <= {qx[s][QUO_WIDTH-2:0], 1'b1};
        end else begin
          rx[s+1] <= shx;
          qx[s+1] <= {qx[s][QUO_WIDTH-2:0], 1'b0};
        end
        if (shy >= RW'(dv[s])) begin
          ry[s+1] <= shy - RW'(dv[s]);
          qy[s+1] <= {qy[s][QUO_WIDTH-2:0], 1'b1};
        end else begin
          ry[s+1] <= shy;
          qy[s+1] <= {qy[s][QUO_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  cpo_ctl_t             cl;
  logic [QUO_WIDTH-1:0] fqx, fqy;
  logic [DW-1:0]        fdv;
  assign cl  = c[DIV_STEPS];
  assign fqx = qx[DIV_STEPS];
  assign fqy = qy[DIV_STEPS];
  assign fdv = dv[DIV_STEPS];

  // sign, penetration, zero on miss
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[DIV_STEPS];
    end
    if (en) begin
      hit <= cl.hit;
      if (cl.hit) begin
        normal_x    <= cl.neg_x ? -OUT_WIDTH'(fqx) : OUT_WIDTH'(fqx);
        normal_y    <= cl.neg_y ? -OUT_WIDTH'(fqy) : OUT_WIDTH'(fqy);
        penetration <= OUT_WIDTH'(cl.rsum) - OUT_WIDTH'(fdv);
      end else begin
        normal_x    <= '0;
        normal_y    <= '0;
        penetration <= '0;
      end
    end
  end

endmodule
